### sv/uhq_pkg.sv
// Shared types and constants for the uniform hysteresis quantizer.
// Used by uhq_serial_div, uhq_serial_mul and uniform_hysteresis_quantizer.
`timescale 1ns / 1ps
`default_nettype none

package uhq_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int MIN_W      = 10;
    localparam int MAX_W      = 11;
    localparam int SPAN_W     = 10;
    localparam int LEVEL_W    = 8;
    localparam int HYST_W     = 8;
    localparam int CMP_W      = (SAMPLE_BITS > MAX_W) ? SAMPLE_BITS : MAX_W;
    localparam int OFF_W      = MAX_W;
    localparam int M_TDATA_W  = 8;

    localparam int DIV_W      = OFF_W;
    localparam int DIVISOR_W  = LEVEL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int MUL_W      = LEVEL_W;
    localparam int MUL_CNT_W  = $clog2(MUL_W);
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MARGIN_W   = PROD_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = MAX_W;

    localparam logic [MIN_W-1:0]   POT_MIN_RST    = MIN_W'(0);
    localparam logic [MAX_W-1:0]   POT_MAX_RST    = MAX_W'(1024);
    localparam logic [SPAN_W-1:0]  POT_SPAN_RST   = SPAN_W'(1023);
    localparam logic [LEVEL_W-1:0] NUM_LEVELS_RST = LEVEL_W'(8);
    localparam logic [HYST_W-1:0]  HYST_RST       = HYST_W'(0);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POT_MIN    = 3'd0,
        REG_POT_MAX    = 3'd1,
        REG_POT_SPAN   = 3'd2,
        REG_NUM_LEVELS = 3'd3,
        REG_HYSTERESIS = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_DIV,
        ST_LAUNCH,
        ST_CAND_DIV,
        ST_DECIDE
    } uhq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### sv/uniform_hysteresis_quantizer.sv
// Top level of the uniform hysteresis quantizer: registers, sequencer and decision.
// Depends on uhq_pkg, uhq_serial_div and uhq_serial_mul.
//
//   channel   dir  handshake             payload
//   s_        in   s_tvalid / s_tready   s_tdata: sample
//   m_        out  m_tvalid / m_tready   m_tdata: level, m_tuser: changed
//   cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each sample takes two passes of the bit-serial divider (step size, then candidate
// level); the product for the boundaries runs beside the second pass. A new sample
// is accepted only in idle, once the previous result is loaded for output.
// Reset is synchronous, active low; clears the held level, resets config registers.
// A stalled result waits in the output register; one further sample is worked
// on meanwhile and then held until the output frees up.
`timescale 1ns / 1ps
`default_nettype none

module uniform_hysteresis_quantizer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [SAMPLE_BITS-1:0] sample
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [uhq_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: [7:0] level
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [uhq_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: [0] changed
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [uhq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [uhq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import uhq_pkg::*;

    logic [MIN_W-1:0]   pot_min_reg;
    logic [MAX_W-1:0]   pot_max_reg;
    logic [SPAN_W-1:0]  pot_span_reg;
    logic [LEVEL_W-1:0] num_levels_reg;
    logic [HYST_W-1:0]  hyst_reg;

    uhq_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [LEVEL_W-1:0]     step_reg;
    logic [LEVEL_W-1:0]     cand_reg;
    logic [LEVEL_W-1:0]     held_reg;
    logic                   m_tvalid_reg;
    logic [LEVEL_W-1:0]     m_level_reg;
    logic                   m_changed_reg;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    div_stat_t            div_stat;
    logic [DIV_W-1:0]     div_quotient;
    logic                 mul_start;
    logic                 mul_busy;
    logic [PROD_W-1:0]    mul_product;

    logic                 s_accept;
    logic                 out_load;
    logic [CMP_W-1:0]     x_val, min_val, max_val, x_clamp;
    logic [OFF_W-1:0]     off_val;
    logic [LEVEL_W-1:0]   step_val;
    logic [LEVEL_W-1:0]   cand_val;
    logic [MARGIN_W-1:0]  upper_bound;
    logic [MARGIN_W-1:0]  lower_reach;
    logic                 move_up, move_down, move;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pot_min_reg    <= POT_MIN_RST;
            pot_max_reg    <= POT_MAX_RST;
            pot_span_reg   <= POT_SPAN_RST;
            num_levels_reg <= NUM_LEVELS_RST;
            hyst_reg       <= HYST_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_POT_MIN:    pot_min_reg    <= cfg_data[MIN_W-1:0];
                REG_POT_MAX:    pot_max_reg    <= cfg_data[MAX_W-1:0];
                REG_POT_SPAN:   pot_span_reg   <= cfg_data[SPAN_W-1:0];
                REG_NUM_LEVELS: num_levels_reg <= cfg_data[LEVEL_W-1:0];
                REG_HYSTERESIS: hyst_reg       <= cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp and offset
    always_comb begin
        x_val   = CMP_W'(sample_reg);
        min_val = CMP_W'(pot_min_reg);
        max_val = CMP_W'(pot_max_reg);
        if (x_val < min_val) begin
            x_clamp = min_val;
        end else if (x_val >= max_val) begin
            x_clamp = (pot_max_reg == '0) ? '0 : max_val - 1'b1;
        end else begin
            x_clamp = x_val;
        end
        off_val = (x_clamp >= min_val) ? OFF_W'(x_clamp - min_val) : '0;
    end

    // saturate step and candidate
    always_comb begin
        step_val = (div_quotient >= DIV_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                       : LEVEL_W'(div_quotient + 1'b1);
        cand_val = (div_quotient > DIV_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                      : LEVEL_W'(div_quotient);
    end

    // hysteresis decision
    always_comb begin
        upper_bound = MARGIN_W'(mul_product) + MARGIN_W'(step_reg) + MARGIN_W'(hyst_reg);
        lower_reach = MARGIN_W'(off_reg) + MARGIN_W'(hyst_reg);
        move_up     = (cand_reg > held_reg) && (MARGIN_W'(off_reg) > upper_bound);
        move_down   = (cand_reg < held_reg) && (MARGIN_W'(mul_product) > lower_reach);
        move        = move_up || move_down;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(pot_span_reg);
        div_divisor  = num_levels_reg;
        mul_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    div_start  = 1'b1;
                    state_next = ST_STEP_DIV;
                end
            end
            ST_STEP_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                div_start    = 1'b1;
                div_dividend = off_reg;
                div_divisor  = step_reg;
                mul_start    = 1'b1;
                state_next   = ST_CAND_DIV;
            end
            ST_CAND_DIV: begin
                if (div_stat.done && !mul_busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_STEP_DIV && div_stat.done) begin
            step_reg <= step_val;
            off_reg  <= off_val;
        end
        if (state_reg == ST_CAND_DIV && div_stat.done) begin
            cand_reg <= cand_val;
        end
        if (out_load) begin
            m_level_reg   <= move ? cand_reg : held_reg;
            m_changed_reg <= move;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                if (move) begin
                    held_reg <= cand_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    uhq_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    uhq_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (step_reg),
        .mplier  (held_reg),
        .busy    (mul_busy),
        .product (mul_product)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_level_reg);
    assign m_tuser  = m_changed_reg;

endmodule

`default_nettype wire

### sv/uhq_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on uhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhq_serial_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [uhq_pkg::DIV_W-1:0]     dividend,
    input  wire logic [uhq_pkg::DIVISOR_W-1:0] divisor,
    output uhq_pkg::div_stat_t                 stat,
    output logic [uhq_pkg::DIV_W-1:0]          quotient
);
    import uhq_pkg::*;

    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

### sv/uhq_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on uhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhq_serial_mul (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [uhq_pkg::MUL_W-1:0] mcand,
    input  wire logic [uhq_pkg::MUL_W-1:0] mplier,
    output logic                           busy,
    output logic [uhq_pkg::PROD_W-1:0]     product
);
    import uhq_pkg::*;

    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    shift_reg;
    logic [MUL_W-1:0]     bits_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg   <= '0;
            shift_reg <= PROD_W'(mcand);
            bits_reg  <= mplier;
        end else if (busy_reg) begin
            if (bits_reg[0]) begin
                acc_reg <= acc_reg + shift_reg;
            end
            shift_reg <= {shift_reg[PROD_W-2:0], 1'b0};
            bits_reg  <= {1'b0, bits_reg[MUL_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for uniform_hysteresis_quantizer: drives samples and register writes,
// predicts each held level and changed flag, and compares them with the results.
// Depends on uhq_pkg and the uniform_hysteresis_quantizer RTL only.
`timescale 1ns / 1ps

module tb;
    import uhq_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } level_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow registers and held level of the predictor
    logic [MIN_W-1:0]   lim_lo = POT_MIN_RST;
    logic [MAX_W-1:0]   lim_hi = POT_MAX_RST;
    logic [SPAN_W-1:0]  span_val = POT_SPAN_RST;
    logic [LEVEL_W-1:0] level_count = NUM_LEVELS_RST;
    logic [HYST_W-1:0]  hyst_val = HYST_RST;
    logic [LEVEL_W-1:0] held_level = '0;

    level_result_t level_q[$];
    int            errors = 0;
    int            cycles = 0;
    bit            tx_gaps = 1'b0;
    bit            rx_gaps = 1'b0;
    int            rx_stall = 0;
    int            walk_pos = 0;

    uniform_hysteresis_quantizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[uniform_hysteresis_quantizer] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts of m_tready low while rx_gaps is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_stall <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        level_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (level_q.size() == 0) begin
                $display("%0t unexpected transaction: level %0d changed %0b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = level_q.pop_front();
                if (m_tdata !== want.level) begin
                    $display("%0t level mismatch: expected %0d actual %0d",
                             $time, want.level, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.changed) begin
                    $display("%0t changed mismatch: expected %0b actual %0b",
                             $time, want.changed, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic void predict_level(input logic [SAMPLE_BITS-1:0] smp);
        int unsigned   x;
        int unsigned   offset;
        int unsigned   step;
        int unsigned   cand;
        longint        margin;
        bit            move;
        level_result_t res;
        x = smp;
        move = 1'b0;
        if (x < lim_lo)
            x = lim_lo;
        else if (x >= lim_hi)
            x = (lim_hi == 0) ? 0 : lim_hi - 1;
        offset = (x >= lim_lo) ? x - lim_lo : 0;
        step = (level_count == 0) ? 255 : span_val / level_count + 1;
        if (step > 255)
            step = 255;
        cand = offset / step;
        if (cand > 255)
            cand = 255;
        if (cand > held_level) begin
            margin = longint'(offset) - longint'(step) * (longint'(held_level) + 1);
            move = margin > longint'(hyst_val);
        end else if (cand < held_level) begin
            margin = longint'(step) * longint'(held_level) - longint'(offset);
            move = margin > longint'(hyst_val);
        end
        res.level = move ? LEVEL_W'(cand) : held_level;
        res.changed = (res.level != held_level);
        held_level = res.level;
        level_q.push_back(res);
    endfunction

    task automatic send_sample(input int smp);
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        predict_level(SAMPLE_BITS'(smp));
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(SAMPLE_BITS'(smp));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic await_results();
        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POT_MIN:    lim_lo = MIN_W'(value);
            REG_POT_MAX:    lim_hi = MAX_W'(value);
            REG_POT_SPAN:   span_val = SPAN_W'(value);
            REG_NUM_LEVELS: level_count = LEVEL_W'(value);
            REG_HYSTERESIS: hyst_val = HYST_W'(value);
            default: ;
        endcase
    endtask

    // write all five registers back to back; optionally hit an unused index last
    task automatic program_limits(input int lo, input int hi, input int span,
                                  input int levels, input int hyst, input bit spare);
        await_results();
        write_reg(REG_POT_MIN, lo);
        write_reg(REG_POT_MAX, hi);
        write_reg(REG_POT_SPAN, span);
        write_reg(REG_NUM_LEVELS, levels);
        write_reg(REG_HYSTERESIS, hyst);
        if (spare)
            write_reg(REG_SPARE, $urandom_range(0, (1 << CFG_DATA_W) - 1));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_ramp();
        send_sample(0);
        send_sample(SAMPLE_TOP);
        send_sample(512);
        send_sample(127);
        send_sample(128);
        send_sample(SAMPLE_TOP);
        send_sample(0);
    endtask

    task automatic test_step_saturation();
        // zero levels, then a single level over the full span
        program_limits(0, 1024, 1023, 0, 0, 1'b0);
        send_sample(SAMPLE_TOP);
        send_sample(0);
        program_limits(0, 1024, 1023, 1, 0, 1'b0);
        send_sample(SAMPLE_TOP);
    endtask

    task automatic test_level_saturation();
        program_limits(0, 1024, 0, 255, 0, 1'b0);
        send_sample(SAMPLE_TOP);
        send_sample(300);
        send_sample(0);
    endtask

    task automatic test_inverted_limits();
        program_limits(600, 300, 1023, 8, 0, 1'b0);
        send_sample(100);
        send_sample(700);
        program_limits(0, 0, 1023, 8, 0, 1'b0);
        send_sample(500);
        program_limits(1023, 1024, 1023, 8, 0, 1'b0);
        send_sample(0);
    endtask

    task automatic test_wide_hysteresis();
        program_limits(0, 1024, 1023, 255, 255, 1'b0);
        send_sample(SAMPLE_TOP);
        send_sample(0);
        // unused index must leave every register untouched
        program_limits(0, 1024, 64, 8, 3, 1'b1);
        send_sample(SAMPLE_TOP);
    endtask

    task automatic random_program(input bit wild);
        int lo;
        int hi;
        int levels;
        int hyst;
        if (wild) begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1024);
        end else begin
            lo = $urandom_range(0, 400);
            hi = $urandom_range(lo + 1, 1024);
        end
        levels = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 32);
        hyst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        program_limits(lo, hi, $urandom_range(0, 1023), levels, hyst,
                       $urandom_range(0, 3) == 0);
    endtask

    // mostly a slow walk that crosses boundaries back and forth, some jumps
    task automatic send_tracking(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3)
                walk_pos = $urandom_range(0, SAMPLE_TOP);
            else
                walk_pos = walk_pos + $urandom_range(0, 80) - 40;
            if (walk_pos < 0)
                walk_pos = 0;
            if (walk_pos > SAMPLE_TOP)
                walk_pos = SAMPLE_TOP;
            send_sample(walk_pos);
        end
    endtask

    task automatic test_random_tracking();
        for (int phase = 0; phase < 6; phase++) begin
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
            random_program(phase == 4);
            send_tracking(25);
            // hold off until the pipeline is empty, then resume
            if (phase == 2)
                await_results();
            send_tracking(30);
        end
    endtask

    task automatic test_steady_stream();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_program(1'b0);
        send_tracking(70);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_default_ramp();
        test_step_saturation();
        test_level_saturation();
        test_inverted_limits();
        test_wide_hysteresis();
        test_random_tracking();
        test_steady_stream();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[uniform_hysteresis_quantizer] OK");
        else
            $display("[uniform_hysteresis_quantizer] ERROR");
        $finish;
    end

endmodule
